// ===== rtl/swm_pkg.sv =====
// shared types and constants of the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   // width and reset value of the window length register
   localparam int LEN_BITS = 6;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd63;

   // command that the sequencer gives to every cell of the chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DROP,
      OP_INSERT
   } cell_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DROP,
      ST_INSERT,
      ST_SELECT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/swm_if.sv =====
// valid/ready channel interfaces of the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

// sample channel
interface swm_req_if #(parameter int DW = 16);
   logic valid;
   logic ready;
   logic signed [DW-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// median channel
interface swm_rsp_if #(parameter int DW = 16);
   logic valid;
   logic ready;
   logic signed [DW-1:0] median;
   logic valid_res;
   modport source (output valid, output median, output valid_res, input ready);
   modport sink (input valid, input median, input valid_res, output ready);
endinterface

// window length write channel
interface swm_csr_if;
   logic valid;
   logic ready;
   logic [swm_pkg::LEN_BITS-1:0] window_len;
   modport source (output valid, output window_len, input ready);
   modport sink (input valid, input window_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/sliding_window_median_top.sv =====
// Running median filter over the last window_len samples. Samples are held in a
// chain of MAX_WINDOW cells kept in ascending order, each with its age. Per item
// the sequencer drops the oldest sample if it leaves the window, inserts the new
// one in sorted place in one chain step, then picks the cell of rank
// window_len/2. An item passes CHECK, INSERT and SELECT while the window fills,
// and CHECK, DROP, CHECK, INSERT and SELECT once it is full; each extra sample
// removed after the length was shortened adds one more DROP and CHECK, since the
// chain drops one sample per step. A finished result waits in an output register,
// so the next item can be accepted while it is not yet taken. median is 0 and
// valid_res is 0 until more than window_len/2 samples are held. A window_len of 0
// acts as 1, and values above MAX_WINDOW act as MAX_WINDOW. The user must write
// window_len only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top #(
   parameter int MAX_WINDOW  = 63,
   parameter int SAMPLE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   swm_req_if.sink   req,
   swm_rsp_if.source rsp,
   swm_csr_if.sink   csr
);
   import swm_pkg::*;

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int EW = (CW > LEN_BITS) ? CW : LEN_BITS;
   localparam int DW = SAMPLE_BITS;

   // control and payload registers
   state_type            state_ff, state_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [DW-1:0] sample_ff, sample_in;
   logic [CW-1:0]        drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] median_ff, median_in;
   logic                 valid_res_ff, valid_res_in;

   cell_op_type          op;
   logic [EW-1:0]        len_ext;
   logic [CW-1:0]        eff_len;
   logic [CW-1:0]        half;
   logic [CW-1:0]        old_pos;
   logic signed [DW-1:0] mid_val;

   logic signed [DW-1:0] cell_val [MAX_WINDOW];
   logic [AW-1:0]        cell_age [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] cell_gt;
   logic [MAX_WINDOW-1:0] cell_old;

   // effective window length, clamped to 1..MAX_WINDOW
   always_comb begin
      len_ext = EW'(len_ff);
      if (len_ext == '0) begin
         eff_len = CW'(1);
      end else if (len_ext > EW'(MAX_WINDOW)) begin
         eff_len = CW'(MAX_WINDOW);
      end else begin
         eff_len = CW'(len_ext);
      end
   end

   assign half = eff_len >> 1;

   // place of the oldest held sample and value of the median rank cell
   always_comb begin
      old_pos = '0;
      mid_val = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (cell_old[i]) begin
            old_pos = old_pos | CW'(i);
         end
         if (half == CW'(i)) begin
            mid_val = mid_val | cell_val[i];
         end
      end
   end

   // cell chain
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      logic signed [DW-1:0] lv, rv;
      logic [AW-1:0]        la, ra;
      logic                 lg;

      if (g == 0) begin : g_first
         assign lv = '0;
         assign la = '0;
         assign lg = 1'b0;
      end else begin : g_left
         assign lv = cell_val[g-1];
         assign la = cell_age[g-1];
         assign lg = cell_gt[g-1];
      end

      if (g == MAX_WINDOW - 1) begin : g_last
         assign rv = cell_val[g];
         assign ra = cell_age[g];
      end else begin : g_right
         assign rv = cell_val[g+1];
         assign ra = cell_age[g+1];
      end

      swm_cell #(
         .IDX (g),
         .DW  (DW),
         .AW  (AW),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .sample    (sample_ff),
         .drop_pos  (drop_ff),
         .count     (count_ff),
         .left_val  (lv),
         .left_age  (la),
         .left_gt   (lg),
         .right_val (rv),
         .right_age (ra),
         .val       (cell_val[g]),
         .age       (cell_age[g]),
         .gt        (cell_gt[g]),
         .oldest    (cell_old[g])
      );
   end

   // handshake outputs
   assign req.ready     = (state_ff == ST_IDLE);
   assign csr.ready     = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.median    = median_ff;
   assign rsp.valid_res = valid_res_ff;

   // sequencer: next state, chain command and output loading
   always_comb begin
      state_in     = state_ff;
      op           = OP_HOLD;
      count_in     = count_ff;
      sample_in    = sample_ff;
      drop_in      = drop_ff;
      len_in       = len_ff;
      median_in    = median_ff;
      valid_res_in = valid_res_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr.valid) begin
         len_in = csr.window_len;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               sample_in = req.sample;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (count_ff >= eff_len) begin
               drop_in  = old_pos;
               state_in = ST_DROP;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_DROP: begin
            op       = OP_DROP;
            count_in = count_ff - CW'(1);
            state_in = ST_CHECK;
         end
         ST_INSERT: begin
            op       = OP_INSERT;
            count_in = count_ff + CW'(1);
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff > half) begin
                  median_in    = mid_val;
                  valid_res_in = 1'b1;
               end else begin
                  median_in    = '0;
                  valid_res_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         len_ff       <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      drop_ff      <= drop_in;
      median_ff    <= median_in;
      valid_res_ff <= valid_res_in;
   end

`ifndef SYNTHESIS
   // a drop step always has a held sample to remove
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> (count_ff != '0))
      else $error("drop step with empty chain");

   // exactly one cell holds the oldest sample whenever one must leave
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CHECK) && (count_ff >= eff_len)) |-> $onehot(cell_old))
      else $error("oldest sample not unique");

   // fill count never passes the chain length
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_WINDOW))
      else $error("fill count above chain length");

   // a new result is only loaded from the select step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SELECT))
      else $error("result loaded outside select step");
`endif

endmodule

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// one cell of the sorted sample chain: value, age and neighbor shifting
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
   parameter int IDX = 0,
   parameter int DW  = 16,
   parameter int AW  = 6,
   parameter int CW  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cell_op_type  op,
   input  logic signed [DW-1:0]  sample,
   input  logic [CW-1:0]         drop_pos,
   input  logic [CW-1:0]         count,
   input  logic signed [DW-1:0]  left_val,
   input  logic [AW-1:0]         left_age,
   input  logic                  left_gt,
   input  logic signed [DW-1:0]  right_val,
   input  logic [AW-1:0]         right_age,
   output logic signed [DW-1:0]  val,
   output logic [AW-1:0]         age,
   output logic                  gt,
   output logic                  oldest
);
   import swm_pkg::*;

   logic signed [DW-1:0] val_ff, val_in;
   logic [AW-1:0]        age_ff, age_in;
   logic                 occ;

   // cell holds a sample when its place is below the fill count
   assign occ    = CW'(IDX) < count;
   // empty cells sort as above every sample
   assign gt     = !occ || (sample < val_ff);
   assign oldest = occ && (CW'(age_ff) == count - CW'(1));
   assign val    = val_ff;
   assign age    = age_ff;

   // drop: cells at or after the dropped place pull from the right
   // insert: cells above the sample push right, the boundary cell takes it
   always_comb begin
      val_in = val_ff;
      age_in = age_ff;
      case (op)
         OP_DROP: begin
            if (occ && (CW'(IDX) >= drop_pos)) begin
               val_in = right_val;
               age_in = right_age;
            end
         end
         OP_INSERT: begin
            if (!gt) begin
               age_in = age_ff + AW'(1);
            end else if (left_gt) begin
               val_in = left_val;
               age_in = left_age + AW'(1);
            end else begin
               val_in = sample;
               age_in = '0;
            end
         end
         default: ;
      endcase
   end

   // sample value carries no reset
   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else begin
         age_ff <= age_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/tb_sliding_window_median_top.sv =====
// testbench of the sliding window median filter: random and directed samples
// checked against a running median predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_sliding_window_median_top;

   import swm_pkg::*;

   localparam int MAX_WIN     = 63;
   localparam int SAMPLE_W    = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type median;
      logic       valid_res;
   } median_result_type;

   logic clock;
   logic reset;

   swm_req_if #(.DW(SAMPLE_W)) req_ch ();
   swm_rsp_if #(.DW(SAMPLE_W)) rsp_ch ();
   swm_csr_if csr_ch ();

   sliding_window_median_top #(
      .MAX_WINDOW (MAX_WIN),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   // predictor state: sorted window with ages
   sample_type          win_val [MAX_WIN];
   int                  win_age [MAX_WIN];
   int                  win_fill = 0;
   logic [LEN_BITS-1:0] win_len  = LEN_RESET;

   // stimulus and checking bookkeeping
   sample_type        pending_samples[$];
   median_result_type expected_medians[$];
   int  queued_count    = 0;
   int  result_count    = 0;
   int  valid_count     = 0;
   int  error_count     = 0;
   int  setting_count   = 0;
   int  hold_requests   = 0;
   int  holds_done      = 0;
   int  hold_left       = 0;
   int  send_gap        = 0;
   int  recv_wait       = 0;
   logic sample_taken   = 1'b0;
   logic result_taken   = 1'b0;
   logic sender_idle_on = 1'b1;
   logic recv_idle_on   = 1'b1;

   // slide the window by one sample and pick the rank len/2 entry
   function automatic median_result_type slide_median(sample_type s);
      int len;
      int n;
      int pos;
      int half;
      int i;
      median_result_type r;
      len = int'(win_len);
      if (len == 0) len = 1;
      if (len > MAX_WIN) len = MAX_WIN;
      n = 0;
      // drop samples leaving the window, age the rest
      for (i = 0; i < win_fill; i++) begin
         if (win_age[i] + 1 < len) begin
            win_val[n] = win_val[i];
            win_age[n] = win_age[i] + 1;
            n++;
         end
      end
      // sorted insert, after equal values
      pos = n;
      while (pos > 0 && win_val[pos-1] > s) begin
         win_val[pos] = win_val[pos-1];
         win_age[pos] = win_age[pos-1];
         pos--;
      end
      win_val[pos] = s;
      win_age[pos] = 0;
      win_fill = n + 1;
      half = len / 2;
      if (win_fill > half) begin
         r.median    = win_val[half];
         r.valid_res = 1'b1;
      end else begin
         r.median    = '0;
         r.valid_res = 1'b0;
      end
      return r;
   endfunction

   // mix of full range values, tight clusters with ties and extremes
   function automatic sample_type draw_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = 16'sh8000;
               1: s = 16'sh7fff;
               2: s = 16'sh0000;
               default: s = 16'shffff;
            endcase
         end
         1, 2, 3: s = sample_type'($signed($urandom_range(0, 6)) - 3);
         default: s = sample_type'($urandom());
      endcase
      return s;
   endfunction

   task automatic queue_sample(sample_type s);
      pending_samples = {pending_samples, s};
      queued_count++;
   endtask

   // wait until every queued item has produced its result
   task automatic wait_drained();
      while (result_count != queued_count) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_window_len(logic [LEN_BITS-1:0] len);
      @(negedge clock);
      csr_ch.valid      = 1'b1;
      csr_ch.window_len = len;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      setting_count++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sample driver, fed from the pending queue
   always @(negedge clock) begin : drive_samples
      logic       offer;
      sample_type next_sample;
      offer       = req_ch.valid && !sample_taken;
      next_sample = req_ch.sample;
      if (reset) begin
         offer = 1'b0;
      end else if (!offer) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_samples.size() > 0) begin
            next_sample = pending_samples.pop_front();
            offer       = 1'b1;
            send_gap    = sender_idle_on ? $urandom_range(0, 8) : 0;
         end
      end
      req_ch.valid  <= offer;
      req_ch.sample <= next_sample;
   end

   // result receiver with per-item stalls and long hold-offs on request
   always @(negedge clock) begin : drive_ready
      logic take;
      take = 1'b1;
      if (reset) begin
         take = 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         take = 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         take = 1'b0;
      end else begin
         if (result_taken) recv_wait = recv_idle_on ? $urandom_range(0, 8) : 0;
         if (recv_wait > 0) begin
            recv_wait--;
            take = 1'b0;
         end
      end
      rsp_ch.ready <= take;
   end

   // handshake monitor: predict on accepted samples, check accepted results
   always @(posedge clock) begin : watch_channels
      median_result_type want;
      sample_taken <= !reset && req_ch.valid && req_ch.ready;
      result_taken <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) win_len = csr_ch.window_len;
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (rsp_ch.valid_res) valid_count++;
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected item median=%0d valid_res=%0b", $realtime,
                        rsp_ch.median, rsp_ch.valid_res);
               error_count++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_ch.median !== want.median) begin
                  $display("%0t: median expected %0d actual %0d", $realtime,
                           want.median, rsp_ch.median);
                  error_count++;
               end
               if (rsp_ch.valid_res !== want.valid_res) begin
                  $display("%0t: valid_res expected %0b actual %0b", $realtime,
                           want.valid_res, rsp_ch.valid_res);
                  error_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_medians = {expected_medians, slide_median(req_ch.sample)};
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int         lens[$];
      int         p;
      int         k;
      int         count;
      int         mode;
      sample_type first_run[$];
      sample_type zero_len_run[$];
      lens         = '{63, 2, 1, 4, 63, 17, 0, 62, 31, 6};
      first_run    = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sd5, 16'sd5,
                       16'sd5, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd1,
                       16'shffff};
      zero_len_run = '{16'sd7, -16'sd7, 16'sh7fff, 16'sh8000};

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.sample     = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.window_len = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: short window with extremes and ties, not yet valid at start
      write_window_len(6'd3);
      foreach (first_run[i]) queue_sample(first_run[i]);
      wait_drained();

      // directed: zero length acts as one
      write_window_len(6'd0);
      foreach (zero_len_run[i]) queue_sample(zero_len_run[i]);
      wait_drained();

      // add a few random lengths
      repeat (3) lens = {lens, int'($urandom_range(0, 63))};

      // random phases; length changes keep the held samples
      for (p = 0; p < lens.size(); p++) begin
         mode           = p % 4;
         sender_idle_on = (mode == 1) || (mode == 3);
         recv_idle_on   = (mode == 2) || (mode == 3);
         if (p >= 10) count = $urandom_range(30, 90);
         else count = (lens[p] >= 31) ? 90 : 40;
         write_window_len(LEN_BITS'(lens[p]));
         if (p == 7) begin
            // sender pauses mid-phase until all results are back
            for (k = 0; k < count / 2; k++) queue_sample(draw_sample());
            wait_drained();
            for (k = count / 2; k < count; k++) queue_sample(draw_sample());
         end else begin
            for (k = 0; k < count; k++) queue_sample(draw_sample());
            // receiver holds off while samples keep coming
            if (p == 0 || p == 4) hold_requests++;
         end
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (expected_medians.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $realtime,
                  expected_medians.size());
         error_count++;
      end
      $display("run covered %0d samples under %0d window lengths", queued_count,
               setting_count);
      $display("%0d results checked, %0d with a valid median, %0d errors", result_count,
               valid_count, error_count);
      if (error_count == 0) begin
         $display("PASS sliding_window_median_top");
      end else begin
         $display("FAIL sliding_window_median_top");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1600000;
      $display("FAIL sliding_window_median_top");
      $finish;
   end

endmodule

`default_nettype wire
